// File: rtl/sdspi_pkg.sv
package sdspi_pkg;

  localparam int SectorBytes = 512;
  localparam int ResponsePolls = 10;
  localparam int Cmd0Tries = 10;
  localparam int DummyBytes = 10;

  // input operations
  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_SYNC = 3'd3;
  localparam logic [2:0] OP_CAP = 3'd4;
  localparam logic [2:0] OP_MISO = 3'd5;
  localparam logic [2:0] OP_WBYTE = 3'd6;
  localparam logic [2:0] OP_TICK = 3'd7;

  // result kinds
  localparam logic [1:0] K_MOSI = 2'd0;
  localparam logic [1:0] K_RDATA = 2'd1;
  localparam logic [1:0] K_NEED = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  // config register indexes
  localparam logic [2:0] R_SEL = 3'd0;
  localparam logic [2:0] R_BUSY = 3'd1;
  localparam logic [2:0] R_TOKEN = 3'd2;
  localparam logic [2:0] R_INIT = 3'd3;
  localparam logic [2:0] R_DELAY = 3'd4;

  typedef enum logic [18:0] {
    PH_IDLE = 19'd1 << 0, PH_DUMMY = 19'd1 << 1, PH_SEL_FIRST = 19'd1 << 2,
    PH_SEL_WAIT = 19'd1 << 3, PH_CMD_TX = 19'd1 << 4, PH_CMD_RESP = 19'd1 << 5,
    PH_R7 = 19'd1 << 6, PH_DESEL = 19'd1 << 7, PH_DELAY = 19'd1 << 8,
    PH_TOKEN = 19'd1 << 9, PH_RDATA = 19'd1 << 10, PH_RCRC = 19'd1 << 11,
    PH_WREADY = 19'd1 << 12, PH_WTOKEN = 19'd1 << 13, PH_WNEED = 19'd1 << 14,
    PH_WDATA = 19'd1 << 15, PH_WCRC = 19'd1 << 16, PH_WRESP = 19'd1 << 17,
    PH_WBUSY = 19'd1 << 18
  } phase_t;

  typedef enum logic [3:0] {
    ST_NONE, ST_CMD0, ST_CMD8, ST_APP_V2, ST_ACMD_V2, ST_CMD58, ST_APP_V1,
    ST_ACMD_V1, ST_CMD1, ST_CMD16, ST_READ, ST_WRITE, ST_SYNC, ST_CSD
  } step_t;

  typedef enum logic [2:0] {
    AF_DONE, AF_SELECT, AF_RETRY, AF_BLOCK, AF_INIT_OK, AF_CAPACITY
  } after_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] sector;
    logic [15:0] count;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic        cs_low;
    logic        fast_clock;
    logic [3:0]  status;
    logic [1:0]  card_type;
    logic [31:0] sector_count;
    logic        last;
  } result_t;

endpackage

// File: rtl/sdspi_if.sv
interface sdspi_in_if;
  logic valid;
  logic ready;
  logic [2:0] operation;
  logic [31:0] sector;
  logic [15:0] block_count;
  logic [7:0] byte_in;
  modport source (output valid, operation, sector, block_count, byte_in, input ready);
  modport sink (input valid, operation, sector, block_count, byte_in, output ready);
endinterface

interface sdspi_out_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic cs_low;
  logic fast_clock;
  logic [3:0] status;
  logic [1:0] card_type;
  logic [31:0] sector_count;
  logic last;
  modport source (output valid, kind, byte_out, cs_low, fast_clock, status, card_type,
                  sector_count, last, input ready);
  modport sink (input valid, kind, byte_out, cs_low, fast_clock, status, card_type,
                sector_count, last, output ready);
endinterface

// File: rtl/sd_card_spi_host_sequencer.sv
// Channel   Dir  Payload
// req_in    in   operation, sector, block_count, byte_in
// res_out   out  kind, byte_out, cs_low, fast_clock, status, card_type,
//                sector_count, last
// cfg       in   cfg_we, cfg_index, cfg_data (plain register write)
// The engine steps once per popped item, writing up to two results into a
// four-entry output fifo; a two-entry input queue decouples intake. A result is
// offered once it has passed the registered input queue and output fifo. One
// item per cycle is sustained while each item gives at most one result and the
// output does not stall; read-data bytes give two and run at the output rate of
// one result per cycle. Ready drops when the input queue fills behind a stalled
// or saturated output. Reset is synchronous on rst; the CSD store is not cleared.
module sd_card_spi_host_sequencer #(
  parameter int ResponsePolls = sdspi_pkg::ResponsePolls
) (
  input  logic clk,
  input  logic rst,
  sdspi_in_if.sink req_in,
  sdspi_out_if.source res_out,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic q_valid, q_pop;
  sdspi_pkg::item_t q_item;

  sdspi_front u_front (
    .clk(clk), .rst(rst), .in_ch(req_in),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  sdspi_back #(.ResponsePolls(ResponsePolls)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .out_ch(res_out)
  );
endmodule

// File: rtl/sdspi_front.sv
// Accepts transactions, packs them and pushes into a two-entry queue.
module sdspi_front (
  input  logic clk,
  input  logic rst,
  sdspi_in_if.sink in_ch,
  output logic q_valid,
  output sdspi_pkg::item_t q_item,
  input  logic q_pop
);
  sdspi_pkg::item_t mem [2];
  logic [1:0] fill;
  logic wptr, rptr;
  logic push;

  assign in_ch.ready = (fill != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (fill != 2'd0);
  assign q_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{op: in_ch.operation, sector: in_ch.sector,
                     count: in_ch.block_count, data: in_ch.byte_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill overflow");
  assert property (@(posedge clk) disable iff (rst) (fill == 2'd2) |-> !in_ch.ready)
    else $error("ready while queue full");
endmodule

// File: rtl/sdspi_back.sv
// Executes one queued item per cycle while the output fifo has room; up to two results into a small output fifo.
module sdspi_back #(
  parameter int ResponsePolls = sdspi_pkg::ResponsePolls
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  sdspi_pkg::item_t q_item,
  output logic q_pop,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  sdspi_out_if.source out_ch
);
  // configuration
  logic [15:0] sel_to, busy_to, tok_to, init_to;
  logic [7:0] delay_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_to <= 16'd200; busy_to <= 16'd500; tok_to <= 16'd200;
      init_to <= 16'd2000; delay_ms <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        sdspi_pkg::R_SEL:   sel_to <= cfg_data;
        sdspi_pkg::R_BUSY:  busy_to <= cfg_data;
        sdspi_pkg::R_TOKEN: tok_to <= cfg_data;
        sdspi_pkg::R_INIT:  init_to <= cfg_data;
        sdspi_pkg::R_DELAY: delay_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // engine state
  sdspi_pkg::phase_t phase, phase_next;
  sdspi_pkg::step_t step, step_next, nstep, nstep_next;
  sdspi_pkg::after_t aft, aft_next;
  logic [9:0] bcnt, bcnt_next;
  logic [3:0] att, att_next;
  logic [15:0] mst, mst_next, lpt, lpt_next;
  logic [47:0] frame, frame_next;
  logic [31:0] resp, resp_next;
  logic [1:0] ckind, ckind_next;
  logic cready, cready_next, cs, cs_next;
  logic [31:0] baddr, baddr_next;
  logic [15:0] bleft, bleft_next;
  logic [3:0] pst, pst_next;
  logic [7:0] csd [16];
  logic csd_we;
  logic [3:0] csd_wa;

  // results of this step
  logic [1:0] nres;
  sdspi_pkg::result_t r0, r1;

  // output fifo (4 entries)
  sdspi_pkg::result_t ob [4];
  logic [1:0] ow, orr;
  logic [2:0] ocnt;
  logic opop;

  assign q_pop = q_valid && (ocnt <= 3'd2);
  assign opop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (ocnt != 3'd0);
  assign out_ch.kind = ob[orr].kind;
  assign out_ch.byte_out = ob[orr].byte_out;
  assign out_ch.cs_low = ob[orr].cs_low;
  assign out_ch.fast_clock = ob[orr].fast_clock;
  assign out_ch.status = ob[orr].status;
  assign out_ch.card_type = ob[orr].card_type;
  assign out_ch.sector_count = ob[orr].sector_count;
  assign out_ch.last = ob[orr].last;

  // capacity decode from csd (registered input, shifts are narrow)
  logic [21:0] c2size;
  logic [11:0] c1size;
  logic [3:0] c1bl;
  logic [2:0] c1m;
  logic [5:0] c1sh;
  logic [63:0] c1prod;
  logic [32:0] cap_wide;
  logic [31:0] cap;
  always_comb begin
    c2size = {csd[7][5:0], csd[8], csd[9]};
    c1bl = csd[5][3:0];
    c1size = {csd[6][1:0], csd[7], csd[8][7:6]};
    c1m = {csd[9][1:0], csd[10][7]};
    c1sh = 6'(c1m) + 6'd2 + 6'(c1bl);
    c1prod = (64'(c1size) + 64'd1) << c1sh;
    if (csd[0][7:6] == 2'b01) cap_wide = (33'(c2size) + 33'd1) << 10;
    else cap_wide = (c1prod[63:9] > 55'hFFFFFFFF) ? 33'h0FFFFFFFF : c1prod[41:9];
    cap = cap_wide[32] ? 32'hFFFFFFFF : cap_wide[31:0];
  end

  // command frame builder
  function automatic logic [47:0] mk_frame(sdspi_pkg::step_t s, logic [31:0] a);
    logic [5:0] c;
    logic [31:0] g;
    logic [7:0] crc;
    c = 6'd0; g = 32'd0;
    case (s)
      sdspi_pkg::ST_CMD8: begin c = 6'd8; g = 32'h000001AA; end
      sdspi_pkg::ST_APP_V2, sdspi_pkg::ST_APP_V1: c = 6'd55;
      sdspi_pkg::ST_ACMD_V2: begin c = 6'd41; g = 32'h40000000; end
      sdspi_pkg::ST_CMD58: c = 6'd58;
      sdspi_pkg::ST_ACMD_V1: c = 6'd41;
      sdspi_pkg::ST_CMD1: c = 6'd1;
      sdspi_pkg::ST_CMD16: begin c = 6'd16; g = 32'(sdspi_pkg::SectorBytes); end
      sdspi_pkg::ST_READ: begin c = 6'd17; g = a; end
      sdspi_pkg::ST_WRITE: begin c = 6'd24; g = a; end
      sdspi_pkg::ST_CSD: c = 6'd9;
      default: c = 6'd0;
    endcase
    crc = (c == 6'd0) ? 8'h95 : (c == 6'd8) ? 8'h87 : 8'h01;
    return {2'b01, c, g, crc};
  endfunction

  always_comb begin
    logic [7:0] rx;
    logic [2:0] op;
    logic [7:0] sb [2];
    logic [1:0] sk [2];
    logic [3:0] ss [2];
    logic [31:0] sc [2];
    logic scs [2];
    logic done_f, in_time;
    sdspi_pkg::step_t st;
    sdspi_pkg::after_t d_act;
    logic [3:0] d_st;
    sdspi_pkg::step_t d_ns;
    logic do_desel, do_cmd, do_sel, do_delay, do_wait, do_resp, do_fin;
    sdspi_pkg::step_t sel_step;
    sdspi_pkg::phase_t wait_ph;
    logic [3:0] done_st;
    logic [31:0] done_sc;
    logic [7:0] rsp;

    phase_next = phase; step_next = step; nstep_next = nstep; aft_next = aft;
    bcnt_next = bcnt; att_next = att; mst_next = mst; lpt_next = lpt;
    frame_next = frame; resp_next = resp; ckind_next = ckind; cready_next = cready;
    cs_next = cs; baddr_next = baddr; bleft_next = bleft; pst_next = pst;
    csd_we = 1'b0; csd_wa = bcnt[3:0];
    nres = 2'd0;
    rx = q_item.data; op = q_item.op;
    for (int i = 0; i < 2; i++) begin
      sb[i] = 8'd0; sk[i] = sdspi_pkg::K_MOSI; ss[i] = 4'd0; sc[i] = 32'd0; scs[i] = 1'b0;
    end
    done_f = 1'b0; in_time = (lpt < init_to); st = step;
    d_act = sdspi_pkg::AF_DONE; d_st = 4'd0; d_ns = sdspi_pkg::ST_NONE;
    do_desel = 1'b0; do_cmd = 1'b0; do_sel = 1'b0; do_delay = 1'b0; do_wait = 1'b0;
    do_resp = 1'b0; do_fin = 1'b0;
    sel_step = sdspi_pkg::ST_NONE; wait_ph = sdspi_pkg::PH_IDLE;
    done_st = 4'd0; done_sc = 32'd0; rsp = 8'd0;

    if (q_pop) begin
      // stage A: primary dispatch
      if (op <= sdspi_pkg::OP_CAP) begin
        if (phase == sdspi_pkg::PH_IDLE) begin
          if (op == sdspi_pkg::OP_INIT) begin
            cready_next = 1'b0; ckind_next = 2'd0; cs_next = 1'b0; bcnt_next = '0;
            phase_next = sdspi_pkg::PH_DUMMY;
            sk[0] = sdspi_pkg::K_MOSI; sb[0] = 8'hFF; nres = 2'd1;
          end else if (!cready || ((op == sdspi_pkg::OP_READ || op == sdspi_pkg::OP_WRITE)
                                   && q_item.count == 16'd0)) begin
            done_f = 1'b1; done_st = 4'd1;
          end else if (op == sdspi_pkg::OP_READ || op == sdspi_pkg::OP_WRITE) begin
            baddr_next = (ckind == 2'd3) ? q_item.sector : {q_item.sector[22:0], 9'd0};
            bleft_next = q_item.count;
            do_sel = 1'b1;
            sel_step = (op == sdspi_pkg::OP_READ) ? sdspi_pkg::ST_READ : sdspi_pkg::ST_WRITE;
          end else begin
            do_sel = 1'b1;
            sel_step = (op == sdspi_pkg::OP_SYNC) ? sdspi_pkg::ST_SYNC : sdspi_pkg::ST_CSD;
          end
        end
      end else if (op == sdspi_pkg::OP_WBYTE) begin
        if (phase == sdspi_pkg::PH_WNEED) begin
          phase_next = sdspi_pkg::PH_WDATA; sb[0] = rx; nres = 2'd1;
        end
      end else if (op == sdspi_pkg::OP_TICK) begin
        if (phase != sdspi_pkg::PH_IDLE) begin
          if (mst != 16'hFFFF) mst_next = mst + 16'd1;
          if (lpt != 16'hFFFF) lpt_next = lpt + 16'd1;
          in_time = (lpt_next < init_to);
          if (phase == sdspi_pkg::PH_DELAY && mst_next >= 16'(delay_ms)) do_fin = 1'b1;
        end
      end else if (phase != sdspi_pkg::PH_IDLE && phase != sdspi_pkg::PH_DELAY &&
                   phase != sdspi_pkg::PH_WNEED) begin
        unique case (phase)
          sdspi_pkg::PH_DUMMY: begin
            bcnt_next = bcnt + 10'd1;
            if (bcnt_next < 10'(sdspi_pkg::DummyBytes)) begin sb[0] = 8'hFF; nres = 2'd1; end
            else begin att_next = '0; do_sel = 1'b1; sel_step = sdspi_pkg::ST_CMD0; end
          end
          sdspi_pkg::PH_SEL_FIRST: begin do_wait = 1'b1; wait_ph = sdspi_pkg::PH_SEL_WAIT; end
          sdspi_pkg::PH_SEL_WAIT: begin
            if (rx == 8'hFF) do_cmd = 1'b1;
            else if (mst < sel_to) begin sb[0] = 8'hFF; nres = 2'd1; end
            else if (step == sdspi_pkg::ST_CMD0) begin
              do_desel = 1'b1; d_act = sdspi_pkg::AF_RETRY;
            end else begin do_desel = 1'b1; d_st = 4'd2; end
          end
          sdspi_pkg::PH_CMD_TX: begin
            bcnt_next = bcnt + 10'd1;
            if (bcnt_next < 10'd6) begin
              sb[0] = frame[47:40]; nres = 2'd1; frame_next = {frame[39:0], 8'd0};
            end else begin
              bcnt_next = '0; phase_next = sdspi_pkg::PH_CMD_RESP; sb[0] = 8'hFF; nres = 2'd1;
            end
          end
          sdspi_pkg::PH_CMD_RESP: begin
            if (!rx[7]) begin do_resp = 1'b1; rsp = rx; end
            else begin
              bcnt_next = bcnt + 10'd1;
              if (bcnt_next >= 10'(ResponsePolls)) begin
                do_resp = 1'b1; rsp = 8'hFF;
              end else begin sb[0] = 8'hFF; nres = 2'd1; end
            end
          end
          sdspi_pkg::PH_R7: begin
            resp_next = {resp[23:0], rx};
            bcnt_next = bcnt + 10'd1;
            if (bcnt_next < 10'd4) begin sb[0] = 8'hFF; nres = 2'd1; end
            else if (step == sdspi_pkg::ST_CMD8) begin
              do_desel = 1'b1;
              if (resp_next[15:0] == 16'h01AA) begin
                d_act = sdspi_pkg::AF_SELECT; d_ns = sdspi_pkg::ST_APP_V2;
              end else d_st = 4'd4;
            end else begin
              ckind_next = resp_next[30] ? 2'd3 : 2'd2;
              do_desel = 1'b1; d_act = sdspi_pkg::AF_INIT_OK;
            end
          end
          sdspi_pkg::PH_DESEL: begin
            case (aft)
              sdspi_pkg::AF_SELECT: begin lpt_next = '0; do_sel = 1'b1; sel_step = nstep; end
              sdspi_pkg::AF_RETRY: begin
                phase_next = sdspi_pkg::PH_DELAY; mst_next = '0;
                if (delay_ms == 8'd0) do_fin = 1'b1;
              end
              sdspi_pkg::AF_BLOCK: begin
                baddr_next = baddr + ((ckind == 2'd3) ? 32'd1 : 32'(sdspi_pkg::SectorBytes));
                bleft_next = bleft - 16'd1;
                if (bleft_next != 16'd0) begin do_sel = 1'b1; sel_step = step; end
                else done_f = 1'b1;
              end
              sdspi_pkg::AF_INIT_OK: begin cready_next = 1'b1; done_f = 1'b1; end
              sdspi_pkg::AF_CAPACITY: begin
                done_f = 1'b1; done_sc = cap; done_st = (cap == 32'd0) ? 4'd12 : 4'd0;
              end
              default: begin done_f = 1'b1; done_st = pst; end
            endcase
          end
          sdspi_pkg::PH_TOKEN: begin
            if (rx == 8'hFE) begin
              bcnt_next = '0; phase_next = sdspi_pkg::PH_RDATA; sb[0] = 8'hFF; nres = 2'd1;
            end else if (mst < tok_to) begin sb[0] = 8'hFF; nres = 2'd1; end
            else begin do_desel = 1'b1; d_st = 4'd9; end
          end
          sdspi_pkg::PH_RDATA: begin
            bcnt_next = bcnt + 10'd1;
            if (step == sdspi_pkg::ST_CSD) begin
              csd_we = 1'b1; sb[0] = 8'hFF; nres = 2'd1;
            end else begin
              sk[0] = sdspi_pkg::K_RDATA; sb[0] = rx; sb[1] = 8'hFF; nres = 2'd2;
            end
            if (bcnt_next >= ((step == sdspi_pkg::ST_CSD) ? 10'd16 :
                              10'(sdspi_pkg::SectorBytes))) begin
              bcnt_next = '0; phase_next = sdspi_pkg::PH_RCRC;
            end
          end
          sdspi_pkg::PH_RCRC: begin
            bcnt_next = bcnt + 10'd1;
            if (bcnt_next < 10'd2) begin sb[0] = 8'hFF; nres = 2'd1; end
            else begin
              do_desel = 1'b1;
              d_act = (step == sdspi_pkg::ST_CSD) ? sdspi_pkg::AF_CAPACITY : sdspi_pkg::AF_BLOCK;
            end
          end
          sdspi_pkg::PH_WREADY: begin
            if (rx == 8'hFF) begin
              phase_next = sdspi_pkg::PH_WTOKEN; sb[0] = 8'hFE; nres = 2'd1;
            end else if (mst < busy_to) begin sb[0] = 8'hFF; nres = 2'd1; end
            else begin do_desel = 1'b1; d_st = 4'd11; end
          end
          sdspi_pkg::PH_WTOKEN: begin
            bcnt_next = '0; phase_next = sdspi_pkg::PH_WNEED;
            sk[0] = sdspi_pkg::K_NEED; nres = 2'd1;
          end
          sdspi_pkg::PH_WDATA: begin
            bcnt_next = bcnt + 10'd1;
            if (bcnt_next < 10'(sdspi_pkg::SectorBytes)) begin
              phase_next = sdspi_pkg::PH_WNEED; sk[0] = sdspi_pkg::K_NEED; nres = 2'd1;
            end else begin
              bcnt_next = '0; phase_next = sdspi_pkg::PH_WCRC; sb[0] = 8'hFF; nres = 2'd1;
            end
          end
          sdspi_pkg::PH_WCRC: begin
            bcnt_next = bcnt + 10'd1;
            if (bcnt_next >= 10'd2) phase_next = sdspi_pkg::PH_WRESP;
            sb[0] = 8'hFF; nres = 2'd1;
          end
          sdspi_pkg::PH_WRESP: begin
            if (rx[4:0] != 5'h05) begin do_desel = 1'b1; d_st = 4'd10; end
            else begin do_wait = 1'b1; wait_ph = sdspi_pkg::PH_WBUSY; end
          end
          sdspi_pkg::PH_WBUSY: begin
            if (rx == 8'hFF) begin
              do_desel = 1'b1;
              d_act = (step == sdspi_pkg::ST_SYNC) ? sdspi_pkg::AF_DONE : sdspi_pkg::AF_BLOCK;
            end else if (mst < busy_to) begin sb[0] = 8'hFF; nres = 2'd1; end
            else begin do_desel = 1'b1; d_st = 4'd11; end
          end
          default: ;
        endcase
      end

      // stage B: response decode
      if (do_resp) begin
        st = step;
        if ((st == sdspi_pkg::ST_APP_V2 || st == sdspi_pkg::ST_APP_V1) && rsp <= 8'd1) begin
          step_next = sdspi_pkg::step_t'(st + 4'd1); do_cmd = 1'b1;
        end else begin
          if (st == sdspi_pkg::ST_APP_V2 || st == sdspi_pkg::ST_APP_V1) begin
            st = sdspi_pkg::step_t'(st + 4'd1); step_next = st;
          end
          do_desel = 1'b1;
          case (st)
            sdspi_pkg::ST_CMD0: begin
              d_act = (rsp == 8'd1) ? sdspi_pkg::AF_SELECT : sdspi_pkg::AF_RETRY;
              d_ns = sdspi_pkg::ST_CMD8;
            end
            sdspi_pkg::ST_CMD8: begin
              if (rsp == 8'd1) begin
                do_desel = 1'b0; bcnt_next = '0; phase_next = sdspi_pkg::PH_R7;
                sb[0] = 8'hFF; nres = 2'd1;
              end else begin d_act = sdspi_pkg::AF_SELECT; d_ns = sdspi_pkg::ST_APP_V1; end
            end
            sdspi_pkg::ST_ACMD_V2: begin
              d_act = (rsp == 8'd0) ? sdspi_pkg::AF_SELECT : sdspi_pkg::AF_RETRY;
              d_ns = sdspi_pkg::ST_CMD58;
            end
            sdspi_pkg::ST_CMD58: begin
              if (rsp != 8'd0) d_st = 4'd6;
              else begin
                do_desel = 1'b0; bcnt_next = '0; phase_next = sdspi_pkg::PH_R7;
                sb[0] = 8'hFF; nres = 2'd1;
              end
            end
            sdspi_pkg::ST_ACMD_V1: begin
              resp_next = 32'(rsp);
              if (rsp == 8'd0) begin
                ckind_next = 2'd2; d_act = sdspi_pkg::AF_SELECT; d_ns = sdspi_pkg::ST_CMD16;
              end else d_act = sdspi_pkg::AF_RETRY;
            end
            sdspi_pkg::ST_CMD1: begin
              if (rsp == 8'd0) begin
                ckind_next = 2'd1; d_act = sdspi_pkg::AF_SELECT; d_ns = sdspi_pkg::ST_CMD16;
              end else d_act = sdspi_pkg::AF_RETRY;
            end
            sdspi_pkg::ST_CMD16: begin
              if (rsp == 8'd0) d_act = sdspi_pkg::AF_INIT_OK; else d_st = 4'd7;
            end
            sdspi_pkg::ST_READ, sdspi_pkg::ST_CSD: begin
              if (rsp != 8'd0) d_st = 4'd8;
              else begin do_desel = 1'b0; do_wait = 1'b1; wait_ph = sdspi_pkg::PH_TOKEN; end
            end
            sdspi_pkg::ST_WRITE: begin
              if (rsp != 8'd0) d_st = 4'd8;
              else begin do_desel = 1'b0; do_wait = 1'b1; wait_ph = sdspi_pkg::PH_WREADY; end
            end
            default: d_st = 4'd1;
          endcase
        end
      end

      // stage C: end of retry pause
      if (do_fin) begin
        case (step)
          sdspi_pkg::ST_CMD0: begin
            att_next = att + 4'd1;
            if (att_next < 4'(sdspi_pkg::Cmd0Tries)) begin
              do_sel = 1'b1; sel_step = sdspi_pkg::ST_CMD0;
            end else begin done_f = 1'b1; done_st = 4'd3; end
          end
          sdspi_pkg::ST_ACMD_V2: begin
            if (in_time) begin do_sel = 1'b1; sel_step = sdspi_pkg::ST_APP_V2; end
            else begin done_f = 1'b1; done_st = 4'd5; end
          end
          sdspi_pkg::ST_ACMD_V1: begin
            if (in_time) begin do_sel = 1'b1; sel_step = sdspi_pkg::ST_APP_V1; end
            else if (resp > 32'd1) begin
              lpt_next = '0; do_sel = 1'b1; sel_step = sdspi_pkg::ST_CMD1;
            end else begin done_f = 1'b1; done_st = 4'd5; end
          end
          sdspi_pkg::ST_CMD1: begin
            if (in_time) begin do_sel = 1'b1; sel_step = sdspi_pkg::ST_CMD1; end
            else begin done_f = 1'b1; done_st = 4'd5; end
          end
          default: begin done_f = 1'b1; done_st = 4'd5; end
        endcase
      end

      // stage D: common sequences
      if (do_sel) begin
        step_next = sel_step; cs_next = 1'b1; phase_next = sdspi_pkg::PH_SEL_FIRST;
        sb[0] = 8'hFF; nres = 2'd1;
      end
      if (do_cmd) begin
        if (step_next == sdspi_pkg::ST_SYNC) begin
          do_wait = 1'b1; wait_ph = sdspi_pkg::PH_WBUSY;
        end else begin
          frame_next = mk_frame(step_next, baddr);
          bcnt_next = '0; phase_next = sdspi_pkg::PH_CMD_TX;
          sb[0] = frame_next[47:40]; frame_next = {frame_next[39:0], 8'd0}; nres = 2'd1;
        end
      end
      if (do_wait) begin
        mst_next = '0; phase_next = wait_ph; sb[0] = 8'hFF; nres = 2'd1;
      end
      if (do_desel) begin
        aft_next = d_act; pst_next = d_st; nstep_next = d_ns; cs_next = 1'b0;
        phase_next = sdspi_pkg::PH_DESEL; sb[0] = 8'hFF; nres = 2'd1;
      end
      if (done_f) begin
        phase_next = sdspi_pkg::PH_IDLE; step_next = sdspi_pkg::ST_NONE;
        sk[0] = sdspi_pkg::K_DONE; sb[0] = 8'd0; ss[0] = done_st; sc[0] = done_sc;
        nres = 2'd1;
      end
    end

    // form results with the flags as they stand after the step
    for (int i = 0; i < 2; i++) scs[i] = cs_next;
    r0 = '{kind: sk[0], byte_out: sb[0], cs_low: scs[0], fast_clock: cready_next,
           status: ss[0], card_type: cready_next ? ckind_next : 2'd0,
           sector_count: sc[0], last: (nres == 2'd1)};
    r1 = '{kind: sk[1], byte_out: sb[1], cs_low: scs[1], fast_clock: cready_next,
           status: ss[1], card_type: cready_next ? ckind_next : 2'd0,
           sector_count: sc[1], last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (csd_we) csd[csd_wa] <= q_item.data;
    if (nres != 2'd0) ob[ow] <= r0;
    if (nres == 2'd2) ob[ow + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdspi_pkg::PH_IDLE; step <= sdspi_pkg::ST_NONE; nstep <= sdspi_pkg::ST_NONE;
      aft <= sdspi_pkg::AF_DONE; bcnt <= '0; att <= '0; mst <= '0; lpt <= '0;
      frame <= '0; resp <= '0; ckind <= '0; cready <= 1'b0; cs <= 1'b0;
      baddr <= '0; bleft <= '0; pst <= '0;
      ow <= '0; orr <= '0; ocnt <= '0;
    end else begin
      phase <= phase_next; step <= step_next; nstep <= nstep_next; aft <= aft_next;
      bcnt <= bcnt_next; att <= att_next; mst <= mst_next; lpt <= lpt_next;
      frame <= frame_next; resp <= resp_next; ckind <= ckind_next;
      cready <= cready_next; cs <= cs_next; baddr <= baddr_next; bleft <= bleft_next;
      pst <= pst_next;
      ow <= ow + nres;
      if (opop) orr <= orr + 2'd1;
      ocnt <= ocnt + 3'(nres) - {2'b0, opop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) ocnt <= 3'd4)
    else $error("result fifo overflow");
  assert property (@(posedge clk) disable iff (rst) (nres != 2'd0) |-> q_pop)
    else $error("result without item");
  assert property (@(posedge clk) disable iff (rst)
    (phase == sdspi_pkg::PH_IDLE) |-> (step == sdspi_pkg::ST_NONE))
    else $error("idle with active step");
  assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
endmodule
